// ----- sv/mpmt_pkg.sv -----
// Shared types, constants and mask helper for the MAC prefix match table.
`timescale 1ns / 1ps

package mpmt_pkg;

  localparam int unsigned RULE_ENTRIES = 64;
  localparam int unsigned MAC_BITS     = 48;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned IN_TDATA_W   = 56;
  localparam int unsigned OUT_TDATA_W  = 8;

  localparam logic [MAC_BITS-1:0] MAC_ONES = '1;

  typedef enum logic {
    FUNC_ADD    = 1'b0,
    FUNC_LOOKUP = 1'b1
  } mpmt_func_e;

  // Item as it travels down the cell chain.
  typedef struct packed {
    logic                valid;
    mpmt_func_e          func;
    logic [MAC_BITS-1:0] key;   // masked key for add, raw address for lookup
    logic [MAC_BITS-1:0] mask;  // mask of the rule being added
    logic                hit;   // lookup matched some rule
    logic                done;  // add resolved (stored or duplicate), or lookup
  } mpmt_tok_t;

  // Top len bits set; lengths above 48 shift everything out and give all ones.
  function automatic logic [MAC_BITS-1:0] mac_mask(input logic [LEN_W-1:0] len);
    return ~(MAC_ONES >> len);
  endfunction

endpackage

// ----- sv/mpmt_cell.sv -----
// One rule cell of the prefix match chain: holds a rule and updates the passing item.
`timescale 1ns / 1ps

module mpmt_cell
  import mpmt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  mpmt_tok_t tok_i,
  output mpmt_tok_t tok_o,
  output logic      rule_valid_o
);

  logic                rule_v_q, rule_v_d;
  logic [MAC_BITS-1:0] rule_key_q, rule_key_d;
  logic [MAC_BITS-1:0] rule_mask_q, rule_mask_d;
  mpmt_tok_t           tok_q, tok_d;
  logic                is_add;
  logic                dup;
  logic                store;
  logic                match;

  always_comb begin
    is_add = tok_i.valid && (tok_i.func == FUNC_ADD) && !tok_i.done;
    dup    = rule_v_q && (rule_mask_q == tok_i.mask) && (rule_key_q == tok_i.key);
    store  = is_add && !rule_v_q;
    match  = rule_v_q && ((tok_i.key & rule_mask_q) == rule_key_q);

    rule_v_d    = rule_v_q;
    rule_key_d  = rule_key_q;
    rule_mask_d = rule_mask_q;
    if (store) begin
      rule_v_d    = 1'b1;
      rule_key_d  = tok_i.key;
      rule_mask_d = tok_i.mask;
    end

    tok_d = tok_i;
    if (is_add && (dup || store)) begin
      tok_d.done = 1'b1;
    end
    if (tok_i.valid && (tok_i.func == FUNC_LOOKUP) && match) begin
      tok_d.hit = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_v_q <= 1'b0;
      tok_q    <= '0;
    end else if (adv_i) begin
      rule_v_q <= rule_v_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rule_key_q  <= rule_key_d;
      rule_mask_q <= rule_mask_d;
    end
  end

  assign tok_o        = tok_q;
  assign rule_valid_o = rule_v_q;

endmodule

// ----- sv/mac_prefix_match_table.sv -----
// Top level of the MAC prefix match table: entry logic, cell chain and output register.
//
// Usage:
//   Slave channel s_axis carries one item per handshake: tuser selects add rule (0)
//   or look up address (1); tdata holds the MAC address and the prefix length.
//   Master channel m_axis returns exactly one result item per input item, in order:
//   hit for a lookup, table_full for an add that found no free entry.
//   Rules live in a chain of RULE_ENTRIES cells, one rule per cell, filled in order.
//   Each item walks the chain one cell per cycle while the chain advances: lookups collect
//   a hit from any matching stored rule, adds resolve as a duplicate or claim the first
//   empty cell. An item passes through the RULE_ENTRIES cell registers, then the result
//   register. Throughput: one item per cycle while the chain is not stalled; items
//   overlap in the chain, and a later item always meets every rule stored by an earlier one.
//   Stall: when the result register is full and m_axis_tready_i is low, the whole
//   chain holds and s_axis_tready_o drops; no item is lost or repeated.
//   Reset: rst_ni (asynchronous, active low) empties every cell and the chain.
`timescale 1ns / 1ps

module mac_prefix_match_table
  import mpmt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [47:0] mac_address, [53:48] prefix_length, [55:54] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] func
  input  logic                   s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [0] hit, [1] table_full, [7:2] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam logic [RULE_ENTRIES-1:0] OCC_ONE = RULE_ENTRIES'(1);

  logic                adv;
  logic [MAC_BITS-1:0] in_addr;
  logic [LEN_W-1:0]    in_len;
  logic [MAC_BITS-1:0] in_mask;
  mpmt_func_e          in_func;

  // Token between cells: tok[i] feeds cell i, tok[RULE_ENTRIES] leaves the chain.
  mpmt_tok_t           tok [RULE_ENTRIES+1];
  logic [RULE_ENTRIES-1:0] occ;

  logic out_valid_q, out_valid_d;
  logic out_hit_q, out_hit_d;
  logic out_full_q, out_full_d;

  // Advance the chain whenever the result register can take what leaves it.
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  assign in_addr = s_axis_tdata_i[MAC_BITS-1:0];
  assign in_len  = s_axis_tdata_i[MAC_BITS+LEN_W-1:MAC_BITS];
  assign in_func = mpmt_func_e'(s_axis_tuser_i);
  assign in_mask = mac_mask(in_len);

  // Build the entry token: an add carries its masked key; a lookup starts resolved.
  always_comb begin
    tok[0].valid = s_axis_tvalid_i && adv;
    tok[0].func  = in_func;
    tok[0].key   = (in_func == FUNC_ADD) ? (in_addr & in_mask) : in_addr;
    tok[0].mask  = in_mask;
    tok[0].hit   = 1'b0;
    tok[0].done  = (in_func == FUNC_LOOKUP);
  end

  for (genvar g = 0; g < RULE_ENTRIES; g++) begin : g_cell
    mpmt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .adv_i        (adv),
      .tok_i        (tok[g]),
      .tok_o        (tok[g+1]),
      .rule_valid_o (occ[g])
    );
  end

  // An add that reaches the end unresolved found every cell taken.
  always_comb begin
    out_valid_d = tok[RULE_ENTRIES].valid;
    out_hit_d   = tok[RULE_ENTRIES].hit;
    out_full_d  = (tok[RULE_ENTRIES].func == FUNC_ADD) && !tok[RULE_ENTRIES].done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_hit_q  <= out_hit_d;
      out_full_q <= out_full_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-2){1'b0}}, out_full_q, out_hit_q};

`ifndef SYNTH
  // Cells fill strictly in order: occupied cells form an unbroken run from cell 0.
  a_occ_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ & (occ + OCC_ONE)) == '0)
    else $error("rule cells not filled in order");

  // A full flag is only possible once every cell holds a rule.
  a_full_needs_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_full_q) |-> (&occ))
    else $error("table_full reported with a free cell");

  // A hit needs at least one stored rule.
  a_hit_needs_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_hit_q) |-> occ[0])
    else $error("hit reported on an empty table");

  // A result never carries both flags.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_full_q))
    else $error("hit and table_full both set");
`endif

endmodule

// ----- sim/mac_prefix_match_table_tb.sv -----
// Self-checking testbench for the MAC prefix match table: stream driver, monitor, rule predictor.
`timescale 1ns / 1ps

module mac_prefix_match_table_tb
  import mpmt_pkg::*;
();

  // Stimulus is split by accepted items into three stall profiles: sender idles lightly and
  // receiver heavily, then the reverse, then no idling at all.
  localparam int PHASE1_END   = 250;
  localparam int PHASE2_END   = 500;
  // Receiver hold-off: starts once this many items are in, long enough to fill the chain.
  localparam int HOLD_AT      = 520;
  localparam int HOLD_CYCLES  = 300;
  // Keep the random part below a full table so the short-prefix rules still fit at the end.
  localparam int FILL_CAP     = 58;
  localparam int RANDOM_ITEMS = 660;
  localparam int DRAIN_CYCLES = RULE_ENTRIES + 16;
  localparam int CYCLE_LIMIT  = 200_000;

  typedef struct packed {
    logic                drain;  // hold this item until every earlier result is back
    mpmt_func_e          func;
    logic [MAC_BITS-1:0] addr;
    logic [LEN_W-1:0]    len;
  } rule_item_t;

  typedef struct packed {
    logic hit;
    logic table_full;
  } match_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  rule_item_t    pending_items[$];
  match_result_t expected_results[$];

  // Predicted table contents; entries below model_count are the rules in use, in fill order.
  logic [MAC_BITS-1:0] model_key [RULE_ENTRIES];
  logic [LEN_W-1:0]    model_len [RULE_ENTRIES];
  int                  model_count = 0;

  // Rules the stimulus believes it has stored; used to aim lookups and duplicate adds.
  logic [MAC_BITS-1:0] gen_keys[$];
  logic [LEN_W-1:0]    gen_lens[$];

  int items_sent = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left = 0;
  bit hold_armed = 1'b1;
  int cycles = 0;
  int mismatches = 0;
  int adds_sent = 0;
  int lookups_sent = 0;
  int hits_seen = 0;
  int fulls_seen = 0;
  int input_stalls = 0;

  mac_prefix_match_table u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [47:0] mac_address, [53:48] prefix_length, [55:54] zero
    .s_axis_tuser_i  (s_tuser),   // [0] func
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // [0] hit, [1] table_full, [7:2] zero
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Lengths above 48 keep the whole address.
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    return (len > MAC_BITS) ? 6'd48 : len;
  endfunction

  // Top len bits set, len already saturated.
  function automatic logic [MAC_BITS-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [MAC_BITS:0] ones;
    if (len == 0) return '0;
    ones = ({{MAC_BITS{1'b0}}, 1'b1} << len) - 1'b1;
    return ones[MAC_BITS-1:0] << (MAC_BITS - len);
  endfunction

  function automatic logic [MAC_BITS-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_BITS-1:0];
  endfunction

  // Mostly mid-length prefixes, some saturating codes, a few short ones that match widely.
  function automatic logic [LEN_W-1:0] new_rule_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return LEN_W'($urandom_range(8, 15));
    if (r < 70) return LEN_W'($urandom_range(16, 48));
    return LEN_W'($urandom_range(49, 63));
  endfunction

  // Apply one accepted item to the predicted table and queue the result it must produce.
  task automatic match_table_apply(input rule_item_t it);
    match_result_t       res;
    logic [LEN_W-1:0]    len;
    logic [MAC_BITS-1:0] key;
    bit                  dup;
    res = '0;
    len = sat_len(it.len);
    if (it.func == FUNC_ADD) begin
      adds_sent++;
      key = it.addr & prefix_mask(len);
      dup = 1'b0;
      for (int i = 0; i < model_count; i++) begin
        if (model_len[i] == len && model_key[i] == key) dup = 1'b1;
      end
      if (!dup) begin
        if (model_count >= RULE_ENTRIES) begin
          res.table_full = 1'b1;
        end else begin
          model_key[model_count] = key;
          model_len[model_count] = len;
          model_count++;
        end
      end
    end else begin
      lookups_sent++;
      for (int i = 0; i < model_count; i++) begin
        if ((it.addr & prefix_mask(model_len[i])) == model_key[i]) res.hit = 1'b1;
      end
    end
    expected_results = {expected_results, res};
  endtask

  task automatic queue_item(input mpmt_func_e func, input logic [MAC_BITS-1:0] addr,
                            input logic [LEN_W-1:0] len, input bit drain);
    rule_item_t it;
    it.drain = drain;
    it.func  = func;
    it.addr  = addr;
    it.len   = len;
    pending_items = {pending_items, it};
  endtask

  task automatic queue_new_rule(input logic [MAC_BITS-1:0] addr, input logic [LEN_W-1:0] len);
    gen_keys = {gen_keys, addr & prefix_mask(sat_len(len))};
    gen_lens = {gen_lens, sat_len(len)};
    queue_item(FUNC_ADD, addr, len, 1'b0);
  endtask

  // One random item: a new rule (with the given odds), a re-add of a stored rule with fresh
  // low bits, a lookup aimed inside a stored prefix, or a lookup of a random address.
  task automatic queue_random_item(input int new_pct, input bit drain);
    int                  r;
    int                  idx;
    logic [LEN_W-1:0]    len;
    logic [MAC_BITS-1:0] addr;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, gen_keys.size() - 1);
    len = gen_lens[idx];
    addr = gen_keys[idx] | (rand_mac() & ~prefix_mask(len));
    if (r < new_pct) begin
      queue_new_rule(rand_mac(), new_rule_len());
      pending_items[$].drain = drain;
    end else if (r < new_pct + 16) begin
      // Full-width rules also answer to every saturating length code.
      if (len == MAC_BITS) len = LEN_W'($urandom_range(48, 63));
      queue_item(FUNC_ADD, addr, len, drain);
    end else if (r < 60) begin
      queue_item(FUNC_LOOKUP, addr, LEN_W'($urandom()), drain);
    end else begin
      queue_item(FUNC_LOOKUP, rand_mac(), LEN_W'($urandom()), drain);
    end
  endtask

  always_comb begin
    if (items_sent < PHASE1_END) begin
      send_idle_pct = 10;
      recv_idle_pct = 74;
    end else if (items_sent < PHASE2_END) begin
      send_idle_pct = 74;
      recv_idle_pct = 10;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Driver: predict each item as it is accepted, then offer the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    rule_item_t head;
    rule_item_t nxt;
    logic       accepted;
    logic       offer;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      accepted = s_tvalid && s_tready;
      if (s_tvalid && !s_tready) input_stalls++;
      if (accepted) begin
        head = pending_items.pop_front();
        match_table_apply(head);
        items_sent <= items_sent + 1;
      end
      // Hold a presented item until it is taken; only choose again when the bus is free.
      if (!s_tvalid || accepted) begin
        offer = pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
        if (offer && pending_items[0].drain && expected_results.size() != 0) offer = 1'b0;
        if (offer) begin
          nxt = pending_items[0];
          s_tdata <= {2'b00, nxt.len, nxt.addr};
          s_tuser <= nxt.func;
        end
        s_tvalid <= offer;
      end
    end
  end

  // Long receiver hold-off, armed once, so the chain backs up into the input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && items_sent >= HOLD_AT) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each result item with the oldest prediction, then pick next ready.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    match_result_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing predicted, tdata %h", m_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[0] !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, m_tdata[0]);
            mismatches++;
          end
          if (m_tdata[1] !== want.table_full) begin
            $error("table_full: expected %0d, got %0d", want.table_full, m_tdata[1]);
            mismatches++;
          end
          hits_seen  += int'(m_tdata[0] === 1'b1);
          fulls_seen += int'(m_tdata[1] === 1'b1);
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("mac_prefix_match_table regression: fail");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [MAC_BITS-1:0] ones;
    ones = '1;

    // Directed: empty table, full-width and saturated lengths, duplicates under the mask.
    queue_item(FUNC_LOOKUP, '0, 6'd0, 1'b0);               // empty table misses
    queue_item(FUNC_LOOKUP, ones, 6'h3F, 1'b0);
    queue_new_rule(ones, 6'd48);
    queue_item(FUNC_LOOKUP, ones, 6'd0, 1'b0);             // exact hit
    queue_item(FUNC_LOOKUP, ones ^ 48'h1, 6'd0, 1'b0);     // last bit off: miss
    queue_item(FUNC_ADD, ones, 6'd63, 1'b0);               // saturates to 48: duplicate
    queue_new_rule('0, 6'd49);                             // saturated, key zero
    queue_item(FUNC_LOOKUP, '0, 6'd0, 1'b0);
    queue_item(FUNC_ADD, '0, 6'd48, 1'b0);                 // duplicate of the saturated rule
    queue_new_rule(48'h001B21_9A3C5E, 6'd24);
    queue_item(FUNC_ADD, 48'h001B21_FFFFFF, 6'd24, 1'b0);  // same masked key: duplicate
    queue_item(FUNC_LOOKUP, 48'h001B21_123456, 6'd24, 1'b0);
    queue_item(FUNC_LOOKUP, 48'h001B22_000000, 6'd24, 1'b0);
    queue_new_rule(48'hAAAA_AAAA_AAAB, 6'd47);
    queue_item(FUNC_LOOKUP, 48'hAAAA_AAAA_AAAA, 6'd5, 1'b0);
    queue_new_rule(48'h5555_5555_5555, 6'd63);
    queue_item(FUNC_LOOKUP, 48'h5555_5555_5554, 6'd32, 1'b0); // compared at 48 bits: miss
    queue_new_rule(rand_mac(), 6'd32);
    queue_item(FUNC_LOOKUP, rand_mac(), 6'd48, 1'b0);

    // Random: pause the sender at the start and at the last stall-profile change.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      queue_random_item((gen_keys.size() < FILL_CAP) ? 9 : 0,
                        n == 0 || pending_items.size() == PHASE2_END);
    end

    // Tail: short prefixes, then the catch-all rule, then overfill the table.
    queue_new_rule(rand_mac(), 6'd1);
    repeat (8) queue_random_item(0, 1'b0);
    queue_new_rule(rand_mac(), 6'd0);
    repeat (16) queue_new_rule(rand_mac(), new_rule_len());
    repeat (50) queue_random_item(20, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      mismatches++;
    end

    $display("Ran %0d adds (%0d rules stored, %0d refused on a full table) and %0d lookups",
             adds_sent, model_count, fulls_seen, lookups_sent);
    $display("  (%0d hits); input back-pressured on %0d cycles, %0d mismatches.",
             hits_seen, input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("mac_prefix_match_table regression: pass");
    end else begin
      $display("mac_prefix_match_table regression: fail");
    end
    $finish;
  end

endmodule
